// ===== hdl/csvt_pkg.sv =====
// ----------------------------------------------------------------------------
// csvt_pkg
// shared types and constants for the csv byte tokenizer
// ----------------------------------------------------------------------------
package csvt_pkg;

  localparam int unsigned LENGTH_BITS_DEFAULT = 16;
  localparam int unsigned OUT_LEN_BITS        = 16;

  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  typedef enum logic {
    OP_TEXT = 1'b0,
    OP_END  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_ROW   = 2'd2,
    KIND_NOROW = 2'd3
  } token_kind_e;

  // one result item as it leaves the tokenizer core
  typedef struct packed {
    logic                    valid;
    token_kind_e             kind;
    logic [7:0]              field_byte;
    logic [OUT_LEN_BITS-1:0] field_length;
    logic                    stream_done;
  } token_t;

endpackage

// ===== hdl/csvt_core.sv =====
// ----------------------------------------------------------------------------
// csvt_core
// quote tracking state and per-byte token decision
// ----------------------------------------------------------------------------
module csvt_core import csvt_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  opcode_e    opcode_i,
  input  logic [7:0] text_byte_i,
  output token_t     token_o
);

  logic                   inside_quotes_q, inside_quotes_d;
  logic                   quote_pending_q, quote_pending_d;
  logic                   row_started_q, row_started_d;
  logic [LENGTH_BITS-1:0] length_count_q, length_count_d;
  logic [LENGTH_BITS-1:0] count_inc;
  logic [OUT_LEN_BITS-1:0] len_sat;
  logic                   quoted_eff;

  // saturating count and its 16-bit report
  assign count_inc = (&length_count_q) ? length_count_q : length_count_q + 1'b1;

  generate
    if (LENGTH_BITS > OUT_LEN_BITS) begin : g_sat_wide
      assign len_sat = (|length_count_q[LENGTH_BITS-1:OUT_LEN_BITS]) ?
                       {OUT_LEN_BITS{1'b1}} : length_count_q[OUT_LEN_BITS-1:0];
    end else begin : g_sat_narrow
      assign len_sat = OUT_LEN_BITS'(length_count_q);
    end
  endgenerate

  always_comb begin
    inside_quotes_d = inside_quotes_q;
    quote_pending_d = quote_pending_q;
    row_started_d   = row_started_q;
    length_count_d  = length_count_q;
    quoted_eff      = inside_quotes_q;
    token_o         = '0;
    token_o.kind    = KIND_DATA;

    if (opcode_i == OP_END) begin
      token_o.valid        = 1'b1;
      token_o.stream_done  = 1'b1;
      token_o.kind         = row_started_q ? KIND_ROW : KIND_NOROW;
      token_o.field_length = row_started_q ? len_sat : '0;
      inside_quotes_d      = 1'b0;
      quote_pending_d      = 1'b0;
      row_started_d        = 1'b0;
      length_count_d       = '0;
    end else begin
      row_started_d   = 1'b1;
      quote_pending_d = 1'b0;
      if (quote_pending_q && text_byte_i == CHAR_QUOTE) begin
        // doubled quote: literal quote byte, section stays open
        token_o.valid      = 1'b1;
        token_o.field_byte = CHAR_QUOTE;
        length_count_d     = count_inc;
      end else begin
        if (quote_pending_q) begin
          quoted_eff      = 1'b0;
          inside_quotes_d = 1'b0;
        end
        if (quoted_eff) begin
          if (text_byte_i == CHAR_QUOTE) begin
            quote_pending_d = 1'b1;
          end else begin
            token_o.valid      = 1'b1;
            token_o.field_byte = text_byte_i;
            length_count_d     = count_inc;
          end
        end else if (text_byte_i == CHAR_QUOTE) begin
          inside_quotes_d = 1'b1;
        end else if (text_byte_i == CHAR_COMMA) begin
          token_o.valid        = 1'b1;
          token_o.kind         = KIND_FIELD;
          token_o.field_length = len_sat;
          length_count_d       = '0;
        end else if (text_byte_i == CHAR_LF) begin
          token_o.valid        = 1'b1;
          token_o.kind         = KIND_ROW;
          token_o.field_length = len_sat;
          length_count_d       = '0;
          row_started_d        = 1'b0;
        end else if (text_byte_i != CHAR_CR) begin
          token_o.valid      = 1'b1;
          token_o.field_byte = text_byte_i;
          length_count_d     = count_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_quotes_q <= 1'b0;
      quote_pending_q <= 1'b0;
      row_started_q   <= 1'b0;
      length_count_q  <= '0;
    end else if (fire_i) begin
      inside_quotes_q <= inside_quotes_d;
      quote_pending_q <= quote_pending_d;
      row_started_q   <= row_started_d;
      length_count_q  <= length_count_d;
    end
  end

  a_pending_in_quotes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    quote_pending_q |-> inside_quotes_q)
    else $error("quote pending outside a quoted section");

  a_pending_resolves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && quote_pending_q |=> !quote_pending_q)
    else $error("pending quote not resolved by next item");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && opcode_i == OP_END |=>
      !inside_quotes_q && !quote_pending_q && !row_started_q && length_count_q == '0)
    else $error("state not cleared after end of input");

endmodule

// ===== hdl/csv_byte_tokenizer.sv =====
// ----------------------------------------------------------------------------
// csv_byte_tokenizer
// streaming csv field tokenizer, when not stalled one byte per cycle
// ----------------------------------------------------------------------------
// usage:
//   input channel: in_valid_i / in_stall_o carry opcode_i and text_byte_i;
//   a transaction is one text byte (opcode 0) or an end-of-input mark
//   (opcode 1). output channel: out_valid_o / out_stall_i carry at most one token
//   per transaction: data byte, field end, row end, or stream end.
//   quote marks, carriage returns outside quotes and the first half of a
//   doubled quote give no token.
// path: an accepted transaction sits in the input register, and its token
//   is registered into the output register when it advances from there.
// throughput: one transaction per cycle while out_stall_i is low, set by the
//   tokenizer core between the input and output registers.
// reset: clears quote, row and length state and empties both registers.
// stall: a stalled token holds in the output register; the input register
//   still moves if its transaction yields no token, otherwise in_stall_o
//   rises and the input side waits.
// ----------------------------------------------------------------------------
module csv_byte_tokenizer import csvt_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [7:0]  text_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  token_kind_o,
  output logic [7:0]  field_byte_o,
  output logic [15:0] field_length_o,
  output logic        stream_done_o
);

  // input register
  logic       in_valid_q, in_valid_d;
  opcode_e    opcode_q;
  logic [7:0] text_byte_q;

  // output register
  logic   out_valid_q, out_valid_d;
  token_t token_q;

  token_t token;
  logic   in_accept;
  logic   advance;

  // move the held transaction into the core when it gives no token or its token has a place
  assign advance    = in_valid_q && (!token.valid || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = (advance && token.valid) ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      opcode_q    <= opcode_e'(opcode_i);
      text_byte_q <= text_byte_i;
    end
    if (advance && token.valid) begin
      token_q <= token;
    end
  end

  csvt_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (advance),
    .opcode_i   (opcode_q),
    .text_byte_i(text_byte_q),
    .token_o    (token)
  );

  assign out_valid_o    = out_valid_q;
  assign token_kind_o   = token_q.kind;
  assign field_byte_o   = token_q.field_byte;
  assign field_length_o = token_q.field_length;
  assign stream_done_o  = token_q.stream_done;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !(advance && token.valid))
    else $error("stalled token overwritten");

  a_done_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && token_q.stream_done |->
      token_q.kind == KIND_ROW || token_q.kind == KIND_NOROW)
    else $error("stream end with wrong token kind");

  a_data_no_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && token_q.kind == KIND_DATA |->
      token_q.field_length == '0 && !token_q.stream_done)
    else $error("data token carries length or done");

endmodule

// ===== bench/tok_check_pkg.sv =====
// ----------------------------------------------------------------------------
// tok_check_pkg
// expected-token predictor and checker for the csv byte tokenizer bench
// ----------------------------------------------------------------------------
package tok_check_pkg;

  import csvt_pkg::*;

  localparam int unsigned RUN_BITS = LENGTH_BITS_DEFAULT;

  typedef struct {
    token_kind_e kind;
    logic [7:0]  fbyte;
    logic [15:0] flen;
    logic        done;
  } token_exp_t;

  class token_scoreboard;
    bit                  quoted;
    bit                  quote_open;
    bit                  row_open;
    logic [RUN_BITS-1:0] run_len;
    token_exp_t          expected_tokens[$];
    int unsigned         failures;

    function new();
      clear_state();
      failures = 0;
    endfunction

    function void clear_state();
      quoted     = 1'b0;
      quote_open = 1'b0;
      row_open   = 1'b0;
      run_len    = '0;
    endfunction

    function void push_token(token_kind_e k, logic [7:0] b, logic [15:0] l, logic d);
      token_exp_t t;
      t.kind  = k;
      t.fbyte = b;
      t.flen  = l;
      t.done  = d;
      expected_tokens.push_back(t);
    endfunction

    function void add_data(logic [7:0] b);
      if (run_len != {RUN_BITS{1'b1}}) run_len++;
      push_token(KIND_DATA, b, 16'd0, 1'b0);
    endfunction

    // reported length clips to the 16-bit output
    function void end_field(token_kind_e k, logic d);
      longint unsigned n;
      n = run_len;
      push_token(k, 8'd0, (n > 65535) ? 16'hFFFF : n[15:0], d);
      run_len = '0;
    endfunction

    // one accepted input transaction
    function void note_input(opcode_e op, logic [7:0] b);
      if (op == OP_END) begin
        if (row_open) end_field(KIND_ROW, 1'b1);
        else push_token(KIND_NOROW, 8'd0, 16'd0, 1'b1);
        clear_state();
        return;
      end
      row_open = 1'b1;
      if (quote_open) begin
        quote_open = 1'b0;
        if (b == CHAR_QUOTE) begin
          add_data(CHAR_QUOTE);
          return;
        end
        quoted = 1'b0;
      end
      if (quoted) begin
        if (b == CHAR_QUOTE) quote_open = 1'b1;
        else add_data(b);
        return;
      end
      if (b == CHAR_QUOTE) quoted = 1'b1;
      else if (b == CHAR_COMMA) end_field(KIND_FIELD, 1'b0);
      else if (b == CHAR_LF) begin
        row_open = 1'b0;
        end_field(KIND_ROW, 1'b0);
      end else if (b != CHAR_CR) add_data(b);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    // one accepted output transaction against the oldest expectation
    function void check_token(logic [1:0] kind, logic [7:0] fb, logic [15:0] fl, logic done);
      token_exp_t t;
      if (expected_tokens.size() == 0) begin
        $error("token with nothing expected: kind %0d byte %0d length %0d done %0d",
               kind, fb, fl, done);
        failures++;
        return;
      end
      t = expected_tokens.pop_front();
      compare_field("token_kind", t.kind, kind);
      compare_field("field_byte", t.fbyte, fb);
      compare_field("field_length", t.flen, fl);
      compare_field("stream_done", t.done, done);
    endfunction

    function int pending();
      return expected_tokens.size();
    endfunction
  endclass

endpackage

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for csv_byte_tokenizer: directed quoting corner cases
// and random csv rows with noise under random and long stalls
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import csvt_pkg::*;
  import tok_check_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned CHUNK_ITEMS = 250;
  localparam int unsigned CHUNKS      = 7;

  typedef struct {
    opcode_e    op;
    logic [7:0] b;
  } text_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        opcode_i;
  logic [7:0]  text_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  token_kind_o;
  logic [7:0]  field_byte_o;
  logic [15:0] field_length_o;
  logic        stream_done_o;

  token_scoreboard sb = new();
  text_item_t      stim_q[$];

  // idling knobs for the sender (gap_max) and the receiver (stall_max, hold_req)
  int unsigned gap_max   = 12;
  int unsigned stall_max = 12;
  bit          hold_req  = 1'b0;
  int unsigned cycle_count = 0;

  csv_byte_tokenizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .text_byte_i   (text_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .token_kind_o  (token_kind_o),
    .field_byte_o  (field_byte_o),
    .field_length_o(field_length_o),
    .stream_done_o (stream_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit, far above the slowest legal run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("csv_byte_tokenizer test failed");
      $finish;
    end
  end

  // both channels sampled at the edge, before any driver update lands
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_token(token_kind_o, field_byte_o, field_length_o, stream_done_o);
      if (in_valid_i && !in_stall_o)
        sb.note_input(opcode_e'(opcode_i), text_byte_i);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------

  function automatic void queue_text(logic [7:0] b);
    text_item_t it;
    it.op = OP_TEXT;
    it.b  = b;
    stim_q.push_back(it);
  endfunction

  // end-of-input carries a random byte, which the block must ignore
  function automatic void queue_end();
    text_item_t it;
    it.op = OP_END;
    it.b  = 8'($urandom_range(0, 255));
    stim_q.push_back(it);
  endfunction

  // any byte that is field data outside quotes
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CHAR_QUOTE || b == CHAR_COMMA || b == CHAR_LF || b == CHAR_CR);
    return b;
  endfunction

  // one field: mostly well formed, sometimes raw noise
  function automatic void queue_field();
    int unsigned style;
    int unsigned n;
    int unsigned r;
    logic [7:0]  b;
    style = $urandom_range(0, 9);
    n     = $urandom_range(0, 8);
    if (style < 5) begin
      repeat (n) queue_text(plain_byte());
    end else if (style < 9) begin
      queue_text(CHAR_QUOTE);
      repeat (n) begin
        r = $urandom_range(0, 9);
        case (r)
          0: begin
            queue_text(CHAR_QUOTE);
            queue_text(CHAR_QUOTE);
          end
          1: queue_text(CHAR_COMMA);
          2: queue_text(CHAR_LF);
          3: queue_text(CHAR_CR);
          default: begin
            b = 8'($urandom_range(0, 255));
            queue_text(b);
            // a lone quote here would close the section, so double it
            if (b == CHAR_QUOTE) queue_text(CHAR_QUOTE);
          end
        endcase
      end
      queue_text(CHAR_QUOTE);
      // stray bytes after the closing quote fall back to unquoted handling
      if ($urandom_range(0, 3) == 0) queue_text(plain_byte());
    end else begin
      repeat (n) queue_text(8'($urandom_range(0, 255)));
    end
  endfunction

  // one row of fields, with assorted line and stream endings
  function automatic void queue_row();
    int unsigned nf;
    int unsigned r;
    nf = $urandom_range(1, 5);
    for (int unsigned i = 0; i < nf; i++) begin
      if (i > 0) queue_text(CHAR_COMMA);
      queue_field();
      if ($urandom_range(0, 29) == 0) queue_end();
    end
    r = $urandom_range(0, 9);
    if (r < 6) queue_text(CHAR_LF);
    else if (r < 8) begin
      queue_text(CHAR_CR);
      queue_text(CHAR_LF);
    end else if (r == 8) queue_end();
    else begin
      queue_text(CHAR_LF);
      queue_end();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // offers one transaction after a random gap and returns at its accepting edge
  task automatic send_item(text_item_t it);
    int unsigned gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= it.op;
    text_byte_i <= it.b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_all();
    while (stim_q.size() > 0) send_item(stim_q.pop_front());
  endtask

  // receiver: random stall before each token, and one long hold-off on request
  task automatic take_tokens();
    int unsigned n;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        n = $urandom_range(0, stall_max);
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  endtask

  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    take_tokens();
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    opcode_i    = OP_TEXT;
    text_byte_i = 8'h00;
    out_stall_i = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: byte extremes and the quoting corner cases
    queue_text(8'h00);
    queue_text(8'hFF);
    queue_text(CHAR_COMMA);       // field end with length 2
    queue_text(CHAR_QUOTE);       // open a quoted section
    queue_text(CHAR_COMMA);       // comma is data inside quotes
    queue_text(CHAR_LF);          // so is newline
    queue_text(CHAR_CR);          // and carriage return
    queue_text(CHAR_QUOTE);       // pending quote
    queue_text(CHAR_QUOTE);       // doubled quote gives one quote byte
    queue_text(CHAR_QUOTE);       // pending again
    queue_text(8'h78);            // closes the section, then plain data
    queue_text(CHAR_CR);          // dropped outside quotes
    queue_text(CHAR_QUOTE);       // reopen quotes in the middle of a field
    queue_text(8'h79);
    queue_text(CHAR_LF);          // newline, quote still open so it is data
    queue_end();                  // flushes the open field
    queue_end();                  // nothing started: stream end without row
    queue_text(CHAR_QUOTE);
    queue_text(8'h71);
    queue_text(CHAR_QUOTE);
    queue_end();                  // pending quote at end of input
    queue_text(CHAR_CR);
    queue_end();                  // row started by a dropped byte alone
    queue_text(8'h7A);
    queue_text(CHAR_LF);
    queue_end();                  // row already closed by newline
    send_all();

    // random rows; the first chunk runs flat out into a long receiver hold
    for (int unsigned c = 0; c < CHUNKS; c++) begin
      if (c == 0) begin
        gap_max   = 0;
        stall_max = 12;
        hold_req  = 1'b1;
      end else begin
        gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 12;
        stall_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
      end
      while (stim_q.size() < CHUNK_ITEMS) queue_row();
      send_all();
    end
    queue_end();
    send_all();
    in_valid_i <= 1'b0;

    // drain, then give stray tokens a chance to show up
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (sb.failures == 0) $display("csv_byte_tokenizer test passed");
    else $display("csv_byte_tokenizer test failed");
    $finish;
  end

endmodule
